// ===== hdl/cdte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cdte_pkg;

	localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
	localparam logic [3:0]  MONTH_MAX    = 4'd12;
	// Leap days in years 1..1969
	localparam logic [31:0] LEAPS_BASE   = 32'd477;
	// floor(n / 100) = (n * 5243) >> 19, exact for n < 4096
	localparam logic [24:0] DIV100_MUL   = 25'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;

	typedef struct packed {
		logic        ok;
		logic [11:0] yr;
		logic [11:0] n;     // yr - 1
		logic [5:0]  q_n;   // n / 100
		logic [5:0]  q_y;   // yr / 100
		logic [3:0]  mon;
		logic [4:0]  mday;
		logic [4:0]  hr;
		logic [5:0]  mins;
		logic [5:0]  secs;
	} s1_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] days;
		logic [16:0] hms;
	} s2_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] prod;
		logic [16:0] hms;
	} s3_t;

	// Days before the given month in a normal year; leap day added after February
	function automatic logic [8:0] days_before_month(input logic leap, input logic [3:0] mon);
		logic [8:0] base;
		begin
			case (mon)
				4'd1:    base = 9'd0;
				4'd2:    base = 9'd31;
				4'd3:    base = 9'd59;
				4'd4:    base = 9'd90;
				4'd5:    base = 9'd120;
				4'd6:    base = 9'd151;
				4'd7:    base = 9'd181;
				4'd8:    base = 9'd212;
				4'd9:    base = 9'd243;
				4'd10:   base = 9'd273;
				4'd11:   base = 9'd304;
				4'd12:   base = 9'd334;
				default: base = 9'd0;
			endcase
			if (leap && (mon > 4'd2)) begin
				base = base + 9'd1;
			end
			return base;
		end
	endfunction

endpackage
`default_nettype wire

// ===== hdl/cdte_year_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdte_year_stage (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [5:0]   second,
	input  wire logic [5:0]   minute,
	input  wire logic [4:0]   hour,
	input  wire logic [4:0]   day_of_month,
	input  wire logic [3:0]   month,
	input  wire logic [11:0]  year,
	output cdte_pkg::s1_t     data_s1
);
	import cdte_pkg::*;

	logic [11:0] n;
	logic [24:0] prod_n;
	logic [24:0] prod_y;
	s1_t         nxt;

	always_comb begin
		n      = year - 12'd1;
		prod_n = 25'(n) * DIV100_MUL;
		prod_y = 25'(year) * DIV100_MUL;
		nxt.ok   = (month != 4'd0) && (month <= MONTH_MAX) && (year >= EPOCH_YEAR);
		nxt.yr   = year;
		nxt.n    = n;
		nxt.q_n  = prod_n[DIV100_SHIFT +: 6];
		nxt.q_y  = prod_y[DIV100_SHIFT +: 6];
		nxt.mon  = month;
		nxt.mday = day_of_month;
		nxt.hr   = hour;
		nxt.mins = minute;
		nxt.secs = second;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cdte_day_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdte_day_stage (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire cdte_pkg::s1_t data_s1,
	output cdte_pkg::s2_t      data_s2
);
	import cdte_pkg::*;

	logic [11:0] yr_off;
	logic [20:0] y365;
	logic [10:0] leaps_n;
	logic [10:0] leaps_y;
	logic        leap;
	logic [8:0]  dbm;
	s2_t         nxt;

	// Leap count through n is n/4 - n/100 + n/400; it steps exactly at leap years
	always_comb begin
		yr_off  = data_s1.yr - EPOCH_YEAR;
		y365    = 21'(yr_off) * 21'd365;
		leaps_n = 11'(data_s1.n >> 2) - 11'(data_s1.q_n) + 11'(data_s1.q_n >> 2);
		leaps_y = 11'(data_s1.yr >> 2) - 11'(data_s1.q_y) + 11'(data_s1.q_y >> 2);
		leap    = (leaps_y != leaps_n);
		dbm     = days_before_month(leap, data_s1.mon);
		nxt.ok   = data_s1.ok;
		nxt.days = 32'(y365) + 32'(leaps_n) + 32'(dbm) + 32'(data_s1.mday)
			- (LEAPS_BASE + 32'd1);
		nxt.hms  = 17'(data_s1.hr) * SECS_PER_HOUR + 17'(data_s1.mins) * SECS_PER_MIN
			+ 17'(data_s1.secs);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cdte_scale_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdte_scale_stage (
	input  wire logic          clk,
	input  wire logic          en_s3,
	input  wire logic          en_s4,
	input  wire cdte_pkg::s2_t data_s2,
	output cdte_pkg::s3_t      data_s3,
	output logic [31:0]        epoch_s4
);
	import cdte_pkg::*;

	// Product kept modulo 2^32
	always_ff @(posedge clk) begin
		if (en_s3) begin
			data_s3.ok   <= data_s2.ok;
			data_s3.prod <= data_s2.days * SECS_PER_DAY;
			data_s3.hms  <= data_s2.hms;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			epoch_s4 <= data_s3.ok ? (data_s3.prod + 32'(data_s3.hms)) : 32'd0;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/calendar_date_to_epoch_seconds.sv =====
// Calendar date/time to seconds since 1970-01-01 00:00:00 (Gregorian).
//
// Input channel: in_valid/in_ready with second, minute, hour, day_of_month,
// month and year. Output channel: out_valid/out_ready with epoch_seconds.
// A transaction happens on a rising edge with valid and ready both high.
//
// Four register stages: year split (divide by 100 via reciprocal multiply),
// day count (closed-form leap count plus month table), day * 86400, and the
// final add into the output register. Each transaction passes through the
// stage registers in order; out_valid is the valid bit of the last stage, and
// throughput is one transaction per cycle while out_ready stays high.
//
// Month 0 or 13..15, or a year below 1970, gives a result of 0. Day 0 counts
// as one day before day 1; hour/minute/second are unchecked; sums wrap mod 2^32.
//
// Reset (arst_n low) clears all stage valid bits; no result is pending after.
// When out_ready is low the pipeline compacts: empty stages keep filling and
// in_ready drops only once all four stages hold a transaction.
`timescale 1ns / 1ps
`default_nettype none
module calendar_date_to_epoch_seconds (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [5:0]   second,
	input  wire logic [5:0]   minute,
	input  wire logic [4:0]   hour,
	input  wire logic [4:0]   day_of_month,
	input  wire logic [3:0]   month,
	input  wire logic [11:0]  year,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [31:0]       epoch_seconds
);
	import cdte_pkg::*;

	// Stage valid bits
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;

	// Stage advance enables: a stage loads when empty or when it drains
	logic en_s1;
	logic en_s2;
	logic en_s3;
	logic en_s4;

	s1_t data_s1;
	s2_t data_s2;
	s3_t data_s3;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1: range check, n = year - 1, both divides by 100
	cdte_year_stage u_year (
		.clk          (clk),
		.en           (en_s1),
		.second       (second),
		.minute       (minute),
		.hour         (hour),
		.day_of_month (day_of_month),
		.month        (month),
		.year         (year),
		.data_s1      (data_s1)
	);

	// Stage 2: elapsed days and seconds within the day
	cdte_day_stage u_day (
		.clk     (clk),
		.en      (en_s2),
		.data_s1 (data_s1),
		.data_s2 (data_s2)
	);

	// Stages 3 and 4: days * 86400, then add and zero rejected dates
	cdte_scale_stage u_scale (
		.clk      (clk),
		.en_s3    (en_s3),
		.en_s4    (en_s4),
		.data_s2  (data_s2),
		.data_s3  (data_s3),
		.epoch_s4 (epoch_seconds)
	);

	// Back-pressure reaches the input only with every stage occupied
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && !out_ready))
		else $error("in_ready low with a pipeline bubble");

	// A stalled day-count stage keeps its contents
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en_s3) |=> (v_s2 && $stable(data_s2)))
		else $error("stage 2 changed while stalled");

	// Bad month or pre-epoch year is flagged in stage 1
	a_reject_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (month == 4'd0 || month > MONTH_MAX || year < EPOCH_YEAR))
		|=> !data_s1.ok)
		else $error("rejected date not flagged");

	// Rejected dates leave as zero
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !data_s3.ok && en_s4) |=> (out_valid && epoch_seconds == 32'd0))
		else $error("rejected date gave nonzero result");

endmodule
`default_nettype wire

// ===== bench/epoch_seconds_checker.sv =====
`timescale 1ns / 1ps
module epoch_seconds_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [5:0]  second,
	input  wire logic [5:0]  minute,
	input  wire logic [4:0]  hour,
	input  wire logic [4:0]  day_of_month,
	input  wire logic [3:0]  month,
	input  wire logic [11:0] year,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] epoch_seconds,
	output int unsigned      failures,
	output int unsigned      pending
);

	typedef struct {
		logic [11:0] yr;
		logic [3:0]  mon;
		logic [4:0]  mday;
		logic [4:0]  hr;
		logic [5:0]  mins;
		logic [5:0]  secs;
		logic [31:0] stamp;
	} date_stamp_t;

	// days before each month in a common year
	localparam int unsigned MONTH_START [0:11] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	date_stamp_t expected_stamps[$];

	function automatic logic [31:0] seconds_since_epoch(input logic [11:0] yr,
		input logic [3:0] mon, input logic [4:0] mday, input logic [4:0] hr,
		input logic [5:0] mins, input logic [5:0] secs);
		bit [63:0] y;
		bit [63:0] n;
		bit [63:0] days;
		bit [63:0] total;
		bit        leap;
		begin
			if (mon < 4'd1 || mon > 4'd12 || yr < 12'd1970) begin
				return 32'd0;
			end
			y = 64'(yr);
			n = y - 64'd1;
			leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
			// leap days in 1970..yr-1
			days = 365 * (y - 1970)
				+ (n / 4 - n / 100 + n / 400)
				- (1969 / 4 - 1969 / 100 + 1969 / 400)
				+ MONTH_START[mon - 4'd1] + ((leap && mon > 4'd2) ? 1 : 0)
				+ 64'(mday);
			days = (days - 64'd1) & 64'hFFFF_FFFF;
			total = days * 86400 + 64'(hr) * 3600 + 64'(mins) * 60 + 64'(secs);
			return total[31:0];
		end
	endfunction

	always @(posedge clk) begin
		date_stamp_t d;
		if (!arst_n) begin
			failures <= 0;
		end else begin
			if (in_valid && in_ready) begin
				d.yr    = year;
				d.mon   = month;
				d.mday  = day_of_month;
				d.hr    = hour;
				d.mins  = minute;
				d.secs  = second;
				d.stamp = seconds_since_epoch(year, month, day_of_month, hour, minute,
					second);
				expected_stamps.push_back(d);
			end
			if (out_valid && out_ready) begin
				if (expected_stamps.size() == 0) begin
					failures <= failures + 1;
					$display("%0t: unexpected result %h", $realtime, epoch_seconds);
				end else begin
					d = expected_stamps.pop_front();
					if (epoch_seconds !== d.stamp) begin
						failures <= failures + 1;
						$display("%0t: %0d-%0d-%0d %0d:%0d:%0d expected %h actual %h",
							$realtime, d.yr, d.mon, d.mday, d.hr, d.mins, d.secs,
							d.stamp, epoch_seconds);
					end
				end
			end
		end
		pending <= unsigned'(expected_stamps.size());
	end

endmodule

// ===== bench/calendar_date_to_epoch_seconds_test.sv =====
`timescale 1ns / 1ps
module calendar_date_to_epoch_seconds_test;

	// cycles with no transaction on either side before the run is abandoned;
	// worst normal stretch is an input gap plus an output stall plus latency
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned RANDOM_ITEMS = 1030;
	// final stretch runs at full rate on both sides
	localparam int unsigned CALM_ITEMS = 150;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [5:0]  second = '0;
	logic [5:0]  minute = '0;
	logic [4:0]  hour = '0;
	logic [4:0]  day_of_month = '0;
	logic [3:0]  month = '0;
	logic [11:0] year = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] epoch_seconds;

	int unsigned failures;
	int unsigned pending;
	int unsigned idle_cycles = 0;
	int unsigned gap_pct = 0;
	bit          calm = 1'b0;

	calendar_date_to_epoch_seconds dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.second       (second),
		.minute       (minute),
		.hour         (hour),
		.day_of_month (day_of_month),
		.month        (month),
		.year         (year),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.epoch_seconds(epoch_seconds)
	);

	// watches both channels, predicts each result and counts mismatches
	epoch_seconds_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.second       (second),
		.minute       (minute),
		.hour         (hour),
		.day_of_month (day_of_month),
		.month        (month),
		.year         (year),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.epoch_seconds(epoch_seconds),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a long stretch with no transaction on either channel means
	// the block has hung (or lost a result the end of run is waiting for).
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side backpressure: ready runs of random length broken by stall
	// bursts of random length; now and then a long run with no stall at all.
	initial begin
		int unsigned run;
		@(negedge clk);
		while (!arst_n) @(negedge clk);
		forever begin
			if (calm) begin
				out_ready <= 1'b1;
				@(negedge clk);
			end else begin
				run = ($urandom_range(7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
				out_ready <= 1'b1;
				repeat (run) @(negedge clk);
				if (!calm) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
				end
			end
		end
	end

	// Present one date at a falling edge and hold it until the transaction.
	// Always entered and left at a falling edge, so valid is assigned at most
	// once per time step.
	task automatic send_date(input logic [11:0] yr, input logic [3:0] mon,
		input logic [4:0] mday, input logic [4:0] hr, input logic [5:0] mins,
		input logic [5:0] secs);
		begin
			if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			year         <= yr;
			month        <= mon;
			day_of_month <= mday;
			hour         <= hr;
			minute       <= mins;
			second       <= secs;
			in_valid     <= 1'b1;
			do @(posedge clk); while (!in_ready);
			@(negedge clk);
		end
	endtask

	initial begin
		logic [11:0] yr;
		logic [3:0]  mon;
		int unsigned pick;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: epoch itself, rejected dates, day zero wrap below the
		// epoch, each leap rule, the 2^31 and 2^32 boundaries, field extremes.
		gap_pct = 20;
		send_date(12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
		send_date(12'd1970, 4'd1,  5'd0,  5'd0,  6'd0,  6'd0);
		send_date(12'd1970, 4'd1,  5'd0,  5'd23, 6'd59, 6'd59);
		send_date(12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0);
		send_date(12'd2020, 4'd0,  5'd15, 5'd12, 6'd0,  6'd0);
		send_date(12'd2020, 4'd13, 5'd15, 5'd12, 6'd0,  6'd0);
		send_date(12'd2020, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
		send_date(12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
		send_date(12'd2000, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0);
		send_date(12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
		send_date(12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
		send_date(12'd2024, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
		send_date(12'd2023, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);
		send_date(12'd2023, 4'd2,  5'd31, 5'd0,  6'd0,  6'd0);
		send_date(12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd7);
		send_date(12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd8);
		send_date(12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15);
		send_date(12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd16);
		send_date(12'd4095, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63);
		send_date(12'd1972, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63);

		// Random: mostly accepted dates with random content, plus a share of
		// rejected ones. Input gap density changes every 64 dates, including
		// stretches with none.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				pick = $urandom_range(2);
				gap_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 40);
			end
			if (i == RANDOM_ITEMS - CALM_ITEMS) begin
				calm = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 50) begin
				yr = 12'($urandom_range(1970, 2200));
			end else if (pick < 85) begin
				yr = 12'($urandom_range(1970, 4095));
			end else begin
				yr = 12'($urandom_range(0, 4095));
			end
			mon = ($urandom_range(99) < 85) ? 4'($urandom_range(1, 12))
				: 4'($urandom_range(0, 15));
			send_date(yr, mon, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
				6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
		end
		in_valid <= 1'b0;

		// drain; the watchdog bounds this wait
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/cdte_pkg.sv
hdl/cdte_year_stage.sv
hdl/cdte_day_stage.sv
hdl/cdte_scale_stage.sv
hdl/calendar_date_to_epoch_seconds.sv
bench/epoch_seconds_checker.sv
bench/calendar_date_to_epoch_seconds_test.sv
